>>> hw/rtl/slra_pkg.sv
// ----------------------------------------------------------------------------
// Slot allocator package
// Shared constants, codes and link types for the slot allocator and its cells.
// ----------------------------------------------------------------------------
package slra_pkg;

  // Pool size and derived widths.
  localparam int SLOT_COUNT = 16;
  localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int REL_W      = 4;
  localparam int GRANT_W    = 4;
  localparam int CMP_W      = (SLOT_IDX_W > REL_W) ? SLOT_IDX_W : REL_W;
  localparam int TIME_W     = 32;
  localparam int TMO_W      = 16;

  // Configuration register map, decoded on the word address bit.
  localparam int          PADDR_W          = 3;
  localparam logic        REG_STALE_TIMEOUT = 1'b0;
  localparam logic [TMO_W-1:0] TMO_RESET   = 16'd60;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_ALLOC   = 2'd1,
    MODE_RELEASE = 2'd2
  } mode_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EVAL = 1'b1
  } state_t;

  typedef logic [SLOT_IDX_W-1:0] slot_idx_t;

  // Commit command broadcast to every cell.
  typedef struct packed {
    logic            alloc;
    logic            release_op;
    logic            use_free;
    logic [REL_W-1:0] release_slot;
  } cell_cmd_t;

  // Priority link handed from one cell to the next.
  typedef struct packed {
    logic      free_found;
    logic      stale_found;
    slot_idx_t free_idx;
    slot_idx_t stale_idx;
  } cell_link_t;

  // Per-cell selection status.
  typedef struct packed {
    logic free_sel;
    logic stale_sel;
  } cell_sel_t;

endpackage

>>> hw/rtl/slra_cell.sv
// ----------------------------------------------------------------------------
// Slot allocator cell
// Holds one slot's busy flag and stamp, judges it free or stale, and takes
// its place in the first-fit priority chain.
// ----------------------------------------------------------------------------
module slra_cell
  import slra_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  slot_idx_t         cell_index,
  input  logic [TIME_W-1:0] time_now,
  input  logic [TMO_W-1:0]  stale_timeout,
  input  cell_cmd_t         cmd,
  input  cell_link_t        link_in,
  output cell_link_t        link_out,
  output cell_sel_t         sel
);

  logic              busy;
  logic [TIME_W-1:0] stamp;
  logic              stale;
  logic [TIME_W-1:0] age;
  logic              rel_hit;
  logic              take;

  // Age check is registered; the pool state only moves at a commit, so the
  // flag is current again by the time the next item is evaluated.
  assign age = time_now - stamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      stale <= 1'b0;
    end else begin
      stale <= busy && (age > {{(TIME_W-TMO_W){1'b0}}, stale_timeout});
    end
  end

  // A cell is selected when it qualifies and no lower cell already did.
  assign sel.free_sel  = !busy && !link_in.free_found;
  assign sel.stale_sel = stale && !link_in.stale_found;

  assign link_out.free_found  = link_in.free_found || !busy;
  assign link_out.stale_found = link_in.stale_found || stale;
  assign link_out.free_idx    = link_in.free_idx | (sel.free_sel ? cell_index : '0);
  assign link_out.stale_idx   = link_in.stale_idx | (sel.stale_sel ? cell_index : '0);

  assign rel_hit = (CMP_W'(cmd.release_slot) == CMP_W'(cell_index));
  assign take    = cmd.alloc && (cmd.use_free ? sel.free_sel : sel.stale_sel);

  // Busy flag update on a grant or a release.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (take) begin
      busy <= 1'b1;
    end else if (cmd.release_op && rel_hit) begin
      busy <= 1'b0;
    end
  end

  // Stamp is written only by a grant.
  always_ff @(posedge clk) begin
    if (take) begin
      stamp <= time_now;
    end
  end

endmodule

>>> hw/rtl/slot_allocator_stale_reclaim.sv
// ----------------------------------------------------------------------------
// Slot allocator with stale reclaim
// First-fit allocation over a row of slot cells; when the pool is full the
// lowest slot granted longer ago than the timeout is reclaimed.
// ----------------------------------------------------------------------------
//   Channel  | Handshake            | Payload
//   ---------+----------------------+----------------------------------
//   input    | in_valid / in_stall  | mode, release_slot
//   output   | out_valid / out_stall| granted, grant_slot, reclaimed
//   config   | APB psel/penable     | stale_timeout at byte address 0
//
// Each item is taken at the transfer edge, then held in the evaluation state in
// which the cell chain resolves the lowest free and lowest stale slot and the
// result is committed. A result waiting on out_stall holds the commit back.
// Reset clears all busy and stale flags, the time counter and the output valid
// flag, and loads a timeout of 60; no clearing pass is needed.
// ----------------------------------------------------------------------------
module slot_allocator_stale_reclaim
  import slra_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         mode,
  input  logic [REL_W-1:0]   release_slot,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               granted,
  output logic [GRANT_W-1:0] grant_slot,
  output logic               reclaimed,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  state_t             state;
  state_t             state_next;
  mode_t              op_mode;
  logic [REL_W-1:0]   op_rel;
  logic [TIME_W-1:0]  time_now;
  logic [TMO_W-1:0]   stale_timeout;
  logic               accept;
  logic               commit;
  logic               any_free;
  logic               any_stale;
  cell_cmd_t          cmd;
  cell_link_t         links [SLOT_COUNT+1];
  cell_sel_t          sels  [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] free_sel_vec;
  logic [SLOT_COUNT-1:0] stale_sel_vec;
  slot_idx_t          win_idx;
  logic [SLOT_IDX_W+GRANT_W-1:0] win_ext;

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stale_timeout <= TMO_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_STALE_TIMEOUT)) begin
      stale_timeout <= pwdata[TMO_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_STALE_TIMEOUT) ?
                  {{(32-TMO_W){1'b0}}, stale_timeout} : 32'd0;

  // Controller: next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_EVAL;
      ST_EVAL: if (commit) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Controller: outputs.
  always_comb begin
    in_stall = 1'b1;
    commit   = 1'b0;
    case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_EVAL: commit   = !out_valid || !out_stall;
      default: in_stall = 1'b1;
    endcase
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Operation register.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode <= mode_t'(mode);
      op_rel  <= release_slot;
    end
  end

  // Seconds counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      time_now <= '0;
    end else if (commit && (op_mode == MODE_TICK)) begin
      time_now <= time_now + TIME_W'(1);
    end
  end

  // Command broadcast to the cells.
  assign cmd.alloc        = commit && (op_mode == MODE_ALLOC);
  assign cmd.release_op   = commit && (op_mode == MODE_RELEASE);
  assign cmd.use_free     = any_free;
  assign cmd.release_slot = op_rel;

  // Chain of slot cells, lowest index first.
  assign links[0] = '0;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    slra_cell u_cell (
      .clk           (clk),
      .rst           (rst),
      .cell_index    (SLOT_IDX_W'(i)),
      .time_now      (time_now),
      .stale_timeout (stale_timeout),
      .cmd           (cmd),
      .link_in       (links[i]),
      .link_out      (links[i+1]),
      .sel           (sels[i])
    );
    assign free_sel_vec[i]  = sels[i].free_sel;
    assign stale_sel_vec[i] = sels[i].stale_sel;
  end

  assign any_free  = links[SLOT_COUNT].free_found;
  assign any_stale = links[SLOT_COUNT].stale_found;
  assign win_idx   = any_free ? links[SLOT_COUNT].free_idx : links[SLOT_COUNT].stale_idx;
  assign win_ext   = {{GRANT_W{1'b0}}, win_idx};

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      if ((op_mode == MODE_ALLOC) && (any_free || any_stale)) begin
        granted    <= 1'b1;
        grant_slot <= win_ext[GRANT_W-1:0];
        reclaimed  <= !any_free;
      end else begin
        granted    <= 1'b0;
        grant_slot <= '0;
        reclaimed  <= 1'b0;
      end
    end
  end

  // Checks.
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !accept)
    else $error("second item taken while one is in evaluation");

  a_free_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(free_sel_vec))
    else $error("more than one cell selected as lowest free slot");

  a_stale_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(stale_sel_vec))
    else $error("more than one cell selected as lowest stale slot");

  a_refused_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !granted) |-> ((grant_slot == '0) && !reclaimed))
    else $error("refused result carries a slot or reclaim flag");

endmodule
